FILE: rtl/qic_pkg.sv
// ============================================================================
// qic_pkg: shared types and constants of the quadratic interpolation unit
// Payload structs for both channels and the front-to-back queue entry.
// ============================================================================
package qic_pkg;

   // Field widths
   localparam int X_W     = 8;
   localparam int Y_W     = 24;
   localparam int FRAC_W  = 16;
   localparam int COEF_W  = 64;
   // Denominator: product of three abscissa differences, signed
   localparam int DEN_W   = 27;
   // Denominator magnitude
   localparam int DM_W    = DEN_W - 1;
   // Coefficient count and divider depth (one quotient bit per stage)
   localparam int NCOEF   = 3;
   localparam int DIV_N   = COEF_W;
   // Queue between front and back, also the credit limit of the block
   localparam int QDEPTH  = 8;
   localparam int QAW     = $clog2(QDEPTH);

   // Coefficient lanes
   localparam int LANE_SQUARE = 0;
   localparam int LANE_LINEAR = 1;
   localparam int LANE_CONST  = 2;

   typedef struct packed {
      logic signed [X_W-1:0] x_first;
      logic signed [Y_W-1:0] y_first;
      logic signed [X_W-1:0] x_second;
      logic signed [Y_W-1:0] y_second;
      logic signed [X_W-1:0] x_third;
      logic signed [Y_W-1:0] y_third;
   } req_payload_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_square;
      logic signed [COEF_W-1:0] coef_linear;
      logic signed [COEF_W-1:0] coef_const;
      logic                     points_coincide;
   } rsp_payload_type;

   // Scaled numerators over the common denominator
   typedef struct packed {
      logic signed [COEF_W-1:0] num_square;
      logic signed [COEF_W-1:0] num_linear;
      logic signed [COEF_W-1:0] num_const;
      logic signed [DEN_W-1:0]  den;
      logic                     coincide;
   } num_item_type;

endpackage

FILE: rtl/quadratic_interpolation_coefficients_unit.sv
// ============================================================================
// quadratic_interpolation_coefficients_unit: Lagrange quadratic fit
// Returns a, b, c (signed Q47.16, truncated toward zero) of the parabola
// through three points, flagging coincident abscissas.
// ============================================================================
// Channels: req_ carries one transaction of three (x, y) points; rsp_ returns
// one transaction of three coefficients and a coincidence flag. Both use
// valid/stall; a transaction moves when valid is high and stall is low.
// Path from request to response: 4 front stages, the queue, 1 sign stage,
// 64 divider stages and 1 output register.
// Throughput: one transaction per cycle while credits remain and no response
// is stalled. Admission is credit based: at most 8 transactions sit in the
// front pipeline and queue together; req_stall rises when all credits are used.
// Coincident abscissas give zero coefficients with points_coincide set.
// Reset clears all valid state and the credit count; no response is pending
// afterward. While rsp_stall holds a valid response the divider pipeline and the
// response register hold; the front keeps draining into the queue and requests
// are taken until credits run out.
// ============================================================================
module quadratic_interpolation_coefficients_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qic_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qic_pkg::rsp_payload_type rsp_payload
);

   logic                  req_accept;
   logic                  front_valid;
   qic_pkg::num_item_type front_data;
   logic                  q_pop, q_empty;
   qic_pkg::num_item_type q_head;
   logic [qic_pkg::QAW:0] credit_ff, credit_in;

   // credit count over front pipeline and queue
   assign req_stall  = (credit_ff == (qic_pkg::QAW+1)'(qic_pkg::QDEPTH));
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      credit_in = credit_ff + (qic_pkg::QAW+1)'(req_accept) - (qic_pkg::QAW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   qic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (req_payload),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   qic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty)
   );

   qic_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/qic_front.sv
// ============================================================================
// qic_front: numerator and denominator pipeline
// Four free-running stages form the exact Lagrange numerators, scaled by
// 2^FRAC_W, and the common denominator. Never stalls; the top level limits
// admission so the queue behind it cannot overflow.
// ============================================================================
module qic_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  qic_pkg::req_payload_type in_data,
   output logic                     out_valid,
   output qic_pkg::num_item_type    out_data
);

   localparam int DW = qic_pkg::X_W + 1;          // differences and sums
   localparam int PW = 2 * qic_pkg::X_W;          // abscissa products
   localparam int TW = qic_pkg::Y_W + DW;         // y times difference
   localparam int AW = TW + 2;                    // sum of three terms
   localparam int BW = TW + DW;                   // term times sum
   localparam int CW = TW + PW;                   // term times product
   localparam int D1 = 2 * DW;                    // partial denominator

   // ---- stage 1: input register
   logic                     v1_ff;
   qic_pkg::req_payload_type p1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      p1_ff <= in_data;
   end

   // differences, sums and products of the abscissas
   logic signed [DW-1:0] w0, w1, w2, d02, s12, s02, s01;
   logic signed [PW-1:0] pr12, pr02, pr01;
   logic signed [DW-1:0] xa, xb, xc;

   always_comb begin
      xa   = DW'(p1_ff.x_first);
      xb   = DW'(p1_ff.x_second);
      xc   = DW'(p1_ff.x_third);
      w0   = xb - xc;
      w1   = xc - xa;
      w2   = xa - xb;
      d02  = xa - xc;
      s12  = xb + xc;
      s02  = xa + xc;
      s01  = xa + xb;
      pr12 = PW'(p1_ff.x_second) * PW'(p1_ff.x_third);
      pr02 = PW'(p1_ff.x_first) * PW'(p1_ff.x_third);
      pr01 = PW'(p1_ff.x_first) * PW'(p1_ff.x_second);
   end

   // ---- stage 2: weighted ordinates, partial denominator
   logic                 v2_ff;
   logic signed [TW-1:0] t0_ff, t1_ff, t2_ff;
   logic signed [D1-1:0] den1_ff;
   logic signed [DW-1:0] w0_ff, s12_ff, s02_ff, s01_ff;
   logic signed [PW-1:0] pr12_ff, pr02_ff, pr01_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      t0_ff   <= TW'(p1_ff.y_first) * TW'(w0);
      t1_ff   <= TW'(p1_ff.y_second) * TW'(w1);
      t2_ff   <= TW'(p1_ff.y_third) * TW'(w2);
      den1_ff <= D1'(w2) * D1'(d02);
      w0_ff   <= w0;
      s12_ff  <= s12;
      s02_ff  <= s02;
      s01_ff  <= s01;
      pr12_ff <= pr12;
      pr02_ff <= pr02;
      pr01_ff <= pr01;
   end

   // ---- stage 3: term products and full denominator
   logic                             v3_ff;
   logic signed [AW-1:0]             a_ff;
   logic signed [BW-1:0]             b0_ff, b1_ff, b2_ff;
   logic signed [CW-1:0]             c0_ff, c1_ff, c2_ff;
   logic signed [qic_pkg::DEN_W-1:0] den3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      a_ff    <= AW'(t0_ff) + AW'(t1_ff) + AW'(t2_ff);
      b0_ff   <= BW'(t0_ff) * BW'(s12_ff);
      b1_ff   <= BW'(t1_ff) * BW'(s02_ff);
      b2_ff   <= BW'(t2_ff) * BW'(s01_ff);
      c0_ff   <= CW'(t0_ff) * CW'(pr12_ff);
      c1_ff   <= CW'(t1_ff) * CW'(pr02_ff);
      c2_ff   <= CW'(t2_ff) * CW'(pr01_ff);
      den3_ff <= qic_pkg::DEN_W'(den1_ff) * qic_pkg::DEN_W'(w0_ff);
   end

   // ---- stage 4: sum, scale, classify
   localparam int CWD = qic_pkg::COEF_W;
   logic signed [CWD-1:0] na, nb, nc;
   logic                  v4_ff;
   qic_pkg::num_item_type item_ff;

   always_comb begin
      na = CWD'(a_ff);
      nb = -(CWD'(b0_ff) + CWD'(b1_ff) + CWD'(b2_ff));
      nc = CWD'(c0_ff) + CWD'(c1_ff) + CWD'(c2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      item_ff.num_square <= na <<< qic_pkg::FRAC_W;
      item_ff.num_linear <= nb <<< qic_pkg::FRAC_W;
      item_ff.num_const  <= nc <<< qic_pkg::FRAC_W;
      item_ff.den        <= den3_ff;
      item_ff.coincide   <= (den3_ff == '0);
   end

   assign out_valid = v4_ff;
   assign out_data  = item_ff;

endmodule

FILE: rtl/qic_queue.sv
// ============================================================================
// qic_queue: short queue between front and back
// Register-array FIFO; head entry is visible without a read cycle.
// ============================================================================
module qic_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  qic_pkg::num_item_type push_data,
   input  logic                  pop,
   output qic_pkg::num_item_type head_data,
   output logic                  empty
);

   qic_pkg::num_item_type        mem_ff [qic_pkg::QDEPTH];
   logic [qic_pkg::QAW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [qic_pkg::QAW:0]        count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (qic_pkg::QAW+1)'(push) - (qic_pkg::QAW+1)'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);

   // ---- assertions
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != (qic_pkg::QAW+1)'(qic_pkg::QDEPTH))
      else $error("qic_queue: push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("qic_queue: pop from empty queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !empty)
      else $error("qic_queue: pushed transaction lost");

endmodule

FILE: rtl/qic_back.sv
// ============================================================================
// qic_back: pipelined restoring dividers and result register
// Three lanes divide the scaled numerator magnitudes by the denominator
// magnitude, one quotient bit per stage; the whole pipe holds on a stall.
// ============================================================================
module qic_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  qic_pkg::num_item_type    q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qic_pkg::rsp_payload_type rsp_payload
);

   localparam int N  = qic_pkg::DIV_N;
   localparam int CW = qic_pkg::COEF_W;
   localparam int DM = qic_pkg::DM_W;
   localparam int L  = qic_pkg::NCOEF;

   logic          advance;
   logic          rsp_valid_ff;
   qic_pkg::rsp_payload_type rsp_payload_ff;

   // pipe state per stage
   logic          v_ff    [N+1];
   logic          coin_ff [N+1];
   logic [L-1:0]  neg_ff  [N+1];
   logic [DM-1:0] dmag_ff [N+1];
   logic [CW-1:0] dvd_ff  [N+1][L];
   logic [DM-1:0] rem_ff  [N+1][L];

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign q_pop   = advance && !q_empty;

   // ---- stage 0: signs and magnitudes
   logic signed [CW-1:0] num [L];
   logic [qic_pkg::DEN_W-1:0] den_abs;

   always_comb begin
      num[qic_pkg::LANE_SQUARE] = q_head.num_square;
      num[qic_pkg::LANE_LINEAR] = q_head.num_linear;
      num[qic_pkg::LANE_CONST]  = q_head.num_const;
      den_abs = q_head.den[qic_pkg::DEN_W-1] ? (~q_head.den + 1'b1) : q_head.den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= q_pop;
      end
      if (advance) begin
         coin_ff[0] <= q_head.coincide;
         dmag_ff[0] <= den_abs[DM-1:0];
         for (int j = 0; j < L; j++) begin
            neg_ff[0][j] <= num[j][CW-1] ^ q_head.den[qic_pkg::DEN_W-1];
            dvd_ff[0][j] <= num[j][CW-1] ? (~num[j] + 1'b1) : num[j];
            rem_ff[0][j] <= '0;
         end
      end
   end

   // ---- divider stages: one quotient bit each
   for (genvar k = 1; k <= N; k++) begin : g_div
      logic [DM:0]   trial [L];
      logic [DM:0]   diff  [L];
      logic [L-1:0]  qbit;

      always_comb begin
         for (int j = 0; j < L; j++) begin
            trial[j] = {rem_ff[k-1][j], dvd_ff[k-1][j][CW-1]};
            diff[j]  = trial[j] - {1'b0, dmag_ff[k-1]};
            qbit[j]  = !diff[j][DM];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (advance) begin
            coin_ff[k] <= coin_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            dmag_ff[k] <= dmag_ff[k-1];
            for (int j = 0; j < L; j++) begin
               rem_ff[k][j] <= qbit[j] ? diff[j][DM-1:0] : trial[j][DM-1:0];
               dvd_ff[k][j] <= {dvd_ff[k-1][j][CW-2:0], qbit[j]};
            end
         end
      end
   end

   // ---- result: restore sign, zero when abscissas coincide
   logic [CW-1:0] coef [L];

   always_comb begin
      for (int j = 0; j < L; j++) begin
         if (coin_ff[N]) begin
            coef[j] = '0;
         end else if (neg_ff[N][j]) begin
            coef[j] = ~dvd_ff[N][j] + 1'b1;
         end else begin
            coef[j] = dvd_ff[N][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v_ff[N];
      end
      if (advance) begin
         rsp_payload_ff.coef_square     <= coef[qic_pkg::LANE_SQUARE];
         rsp_payload_ff.coef_linear     <= coef[qic_pkg::LANE_LINEAR];
         rsp_payload_ff.coef_const      <= coef[qic_pkg::LANE_CONST];
         rsp_payload_ff.points_coincide <= coin_ff[N];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: tb/qic_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// qic_checker: response predictor and scoreboard for the quadratic fit unit
// Watches both channels, computes the expected coefficients of each accepted
// request and compares every accepted response against the oldest one.
// ============================================================================
module qic_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  qic_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  qic_pkg::rsp_payload_type rsp_payload,
   output int                       fail_count,
   output int                       pending_count
);

   qic_pkg::rsp_payload_type coef_queue[$];

   // Exact numerators over the common denominator, scaled and truncated
   function automatic qic_pkg::rsp_payload_type fit_parabola(
      qic_pkg::req_payload_type p);
      qic_pkg::rsp_payload_type r;
      longint x0, x1, x2, y0, y1, y2, t0, t1, t2, den, na, nb, nc;
      x0 = longint'(p.x_first);
      x1 = longint'(p.x_second);
      x2 = longint'(p.x_third);
      y0 = longint'(p.y_first);
      y1 = longint'(p.y_second);
      y2 = longint'(p.y_third);
      den = (x0 - x1) * (x0 - x2) * (x1 - x2);
      r = '0;
      if (den == 0) begin
         r.points_coincide = 1'b1;
         return r;
      end
      t0 = y0 * (x1 - x2);
      t1 = y1 * (x2 - x0);
      t2 = y2 * (x0 - x1);
      na = t0 + t1 + t2;
      nb = -(t0 * (x1 + x2) + t1 * (x0 + x2) + t2 * (x0 + x1));
      nc = t0 * (x1 * x2) + t1 * (x0 * x2) + t2 * (x0 * x1);
      // SV signed division truncates toward zero
      r.coef_square = (na * 65536) / den;
      r.coef_linear = (nb * 65536) / den;
      r.coef_const  = (nc * 65536) / den;
      return r;
   endfunction

   assign pending_count = coef_queue.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      qic_pkg::rsp_payload_type exp_r;
      if (!reset) begin
         if (req_valid && !req_stall)
            coef_queue.push_back(fit_parabola(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (coef_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("ERROR: unexpected response %h", rsp_payload);
            end else begin
               exp_r = coef_queue.pop_front();
               if (rsp_payload !== exp_r) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("ERROR: sq exp %0d got %0d | lin exp %0d got %0d | ",
                              exp_r.coef_square, rsp_payload.coef_square,
                              exp_r.coef_linear, rsp_payload.coef_linear,
                              "const exp %0d got %0d | coin exp %0b got %0b",
                              exp_r.coef_const, rsp_payload.coef_const,
                              exp_r.points_coincide, rsp_payload.points_coincide);
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: stimulus and verdict for the quadratic interpolation unit
// Drives directed and random point sets in bursts, stalls the response side
// on its own pattern with one long hold-off, and reports the checker result.
// ============================================================================
module tb_top;

   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 200;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   qic_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   qic_pkg::rsp_payload_type rsp_payload;
   int                       fail_count;
   int                       pending_count;
   logic                     stim_done = 1'b0;

   always #10 clock = ~clock;

   quadratic_interpolation_coefficients_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   qic_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Random point set; x values copied from one another at times to hit ties
   function automatic qic_pkg::req_payload_type random_points();
      qic_pkg::req_payload_type p;
      p = qic_pkg::req_payload_type'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 7) == 0) p.x_second = p.x_first;
      if ($urandom_range(0, 7) == 0) p.x_third = p.x_second;
      if ($urandom_range(0, 7) == 0) p.x_third = p.x_first;
      return p;
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_points(qic_pkg::req_payload_type p);
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender: bursts with random gaps between them
   task automatic send_burst(qic_pkg::req_payload_type p, ref int burst_left);
      int gap;
      send_points(p);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
   endtask

   // Receiver: random stall pattern, one long hold-off early in the run
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      repeat (40) @(posedge clock);
      rsp_stall <= 1'b1;
      hold = 0;
      while (hold < 150) begin
         @(posedge clock);
         hold++;
      end
      forever begin
         case ($urandom_range(0, 3))
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 4) == 0);
            default: rsp_stall <= 1'b1;
         endcase
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      qic_pkg::req_payload_type p;
      int burst_left;
      int drain;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 20);
      // Directed: field extremes, close and far abscissas, coincidences
      send_burst('{8'sd127, 24'sh7FFFFF, -8'sd128, -24'sd8388608, 8'sd0, 24'sh7FFFFF},
                 burst_left);
      send_burst('{-8'sd128, -24'sd8388608, 8'sd127, 24'sh7FFFFF, 8'sd126, -24'sd8388608},
                 burst_left);
      send_burst('{8'sd0, 24'sd0, 8'sd1, 24'sd1, 8'sd2, 24'sd4}, burst_left);
      send_burst('{8'sd1, 24'sd5, 8'sd2, -24'sd3, 8'sd3, 24'sd7}, burst_left);
      send_burst('{-8'sd1, 24'sd1, 8'sd0, 24'sd0, 8'sd1, -24'sd1}, burst_left);
      send_burst('{-8'sd128, 24'sh7FFFFF, -8'sd127, -24'sd8388608, 8'sd127, 24'sh7FFFFF},
                 burst_left);
      send_burst('{8'sd5, 24'sd1, 8'sd5, 24'sd2, 8'sd9, 24'sd3}, burst_left);
      send_burst('{8'sd5, 24'sd1, 8'sd9, 24'sd2, 8'sd9, 24'sd3}, burst_left);
      send_burst('{-8'sd7, 24'sd1, 8'sd9, 24'sd2, -8'sd7, 24'sd3}, burst_left);
      send_burst('{8'sd3, 24'sd1, 8'sd3, 24'sd2, 8'sd3, 24'sd3}, burst_left);
      send_burst('{8'sd10, 24'sd0, 8'sd20, 24'sd0, 8'sd30, 24'sd0}, burst_left);
      send_burst('{8'sd10, 24'sd1, 8'sd20, 24'sd1, 8'sd30, 24'sd1}, burst_left);
      send_burst('1, burst_left);
      send_burst('{8'sd127, -24'sd8388608, 8'sd0, 24'sh7FFFFF, -8'sd128, 24'sh7FFFFF},
                 burst_left);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         p = random_points();
         send_burst(p, burst_left);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      stim_done = 1'b1;
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      if (!stim_done) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule

FILE: quadratic_interpolation_coefficients_unit.f
rtl/qic_pkg.sv
rtl/qic_front.sv
rtl/qic_queue.sv
rtl/qic_back.sv
rtl/quadratic_interpolation_coefficients_unit.sv
tb/qic_checker.sv
tb/tb_top.sv
